// ----- design/triangle_normal_generator_assert.svh -----
// Assertion macros shared by the triangle normal generator RTL.
// Needs clk and rst_n in the scope of the including module.
`ifndef TRIANGLE_NORMAL_GENERATOR_ASSERT_SVH
`define TRIANGLE_NORMAL_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TNG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TNG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tng_pkg.sv -----
// Types and constants of the triangle normal generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tng_pkg;

  localparam int POS_W  = 16;
  localparam int EDGE_W = 17;
  localparam int IDX_W  = 16;

  localparam logic [1:0] MODE_LIST  = 2'd0;
  localparam logic [1:0] MODE_STRIP = 2'd1;
  localparam logic [1:0] MODE_FAN   = 2'd2;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [EDGE_W-1:0] edge_t;
  typedef logic [IDX_W-1:0]         idx_t;

  // One triangle handed from the front to the back.
  typedef struct packed {
    edge_t e1x;
    edge_t e1y;
    edge_t e1z;
    edge_t e2x;
    edge_t e2y;
    edge_t e2z;
    logic  flip;
    logic  three;   // emit three results, else one
    logic  last;    // third result closes the range
    idx_t  idx0;
    idx_t  idx1;
    idx_t  idx2;
  } job_t;

endpackage
`default_nettype wire

// ----- design/triangle_normal_generator.sv -----
// Channel  | dir | data                                        | side band
// in_      | in  | tdata: pos_x, pos_y, pos_z                  | tlast: last_vertex
// out_     | out | tdata: normal_x, normal_y, normal_z, index   | tuser: degenerate, tlast: last
// cfg_     | in  | wr_data: primitive_mode                     | wr_en
// A triangle passes through the back end's cross product, sign, normalizing shift, squaring,
// bit-serial square root, divider set-up, bit-serial division and clamp before its results,
// then one result per cycle while the receiver takes them.
// A degenerate triangle goes from the sign step straight to its results.
// Vertices are taken while the queue is not full; a two-entry queue buffers triangles.
// Reset is synchronous, active low; an output register holds a stalled result.
`timescale 1ns / 1ps
`default_nettype none
module triangle_normal_generator #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data,     // primitive_mode
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,        // pos_x, pos_y, pos_z
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,       // normal_x, normal_y, normal_z, vertex_index
  output logic             out_tuser,       // degenerate
  output logic             out_tlast
);

  logic          push, q_full, q_valid, q_pop;
  tng_pkg::job_t push_data, q_data;

  tng_front u_front (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .push, .push_data, .q_full
  );

  tng_queue u_queue (
    .clk, .rst_n, .push, .push_data, .full(q_full),
    .pop(q_pop), .pop_data(q_data), .valid(q_valid)
  );

  tng_back #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_pop,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

endmodule
`default_nettype wire

// ----- design/tng_queue.sv -----
// Two-entry job queue between the front and the back.
// Uses tng_pkg::job_t.
`timescale 1ns / 1ps
`default_nettype none
module tng_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tng_pkg::job_t push_data,
  output logic               full,
  input  wire logic          pop,
  output tng_pkg::job_t      pop_data,
  output logic               valid
);

  tng_pkg::job_t slot_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;

  assign full     = (count_r == 2'd2);
  assign valid    = (count_r != 2'd0);
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/tng_front.sv -----
// Front: takes vertices, tracks the primitive assembly and builds triangle jobs.
// Uses tng_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tng_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic [1:0]    cfg_wr_data,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [47:0]   in_tdata,
  input  wire logic          in_tlast,
  output logic               push,
  output tng_pkg::job_t      push_data,
  input  wire logic          q_full
);

  logic [1:0]     mode_r;
  logic [1:0]     seen_r;
  tng_pkg::idx_t  count_r;
  tng_pkg::pos_t  a_r [3];
  tng_pkg::pos_t  b_r [3];
  tng_pkg::pos_t  anc_r [3];
  tng_pkg::pos_t  p [3];
  tng_pkg::pos_t  p0 [3];
  tng_pkg::edge_t e1 [3];
  tng_pkg::edge_t e2 [3];
  logic           take;
  logic           is_strip;
  logic           is_fan;

  assign in_tready = ~q_full;
  assign take      = in_tvalid & in_tready;
  assign is_strip  = (mode_r == tng_pkg::MODE_STRIP);
  assign is_fan    = (mode_r == tng_pkg::MODE_FAN);

  assign p[0] = in_tdata[15:0];
  assign p[1] = in_tdata[31:16];
  assign p[2] = in_tdata[47:32];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p0[i] = is_fan ? anc_r[i] : a_r[i];
      e1[i] = tng_pkg::edge_t'(b_r[i]) - tng_pkg::edge_t'(p0[i]);
      e2[i] = tng_pkg::edge_t'(p[i]) - tng_pkg::edge_t'(p0[i]);
    end
  end

  always_comb begin
    push_data.e1x  = e1[0];
    push_data.e1y  = e1[1];
    push_data.e1z  = e1[2];
    push_data.e2x  = e2[0];
    push_data.e2y  = e2[1];
    push_data.e2z  = e2[2];
    push_data.flip = is_strip & count_r[0];
    if (is_fan) begin
      push_data.idx0  = count_r - 16'd1;
      push_data.idx1  = count_r;
      push_data.idx2  = '0;
      push_data.three = in_tlast;
      push_data.last  = 1'b1;
    end else if (is_strip) begin
      push_data.idx0  = count_r - 16'd2;
      push_data.idx1  = count_r - 16'd1;
      push_data.idx2  = count_r;
      push_data.three = in_tlast;
      push_data.last  = 1'b1;
    end else begin
      push_data.idx0  = count_r - 16'd2;
      push_data.idx1  = count_r - 16'd1;
      push_data.idx2  = count_r;
      push_data.three = 1'b1;
      push_data.last  = in_tlast;
    end
  end

  assign push = take & (seen_r == 2'd2);

  always_ff @(posedge clk) begin
    if (take) begin
      case (seen_r)
        2'd0: begin
          if (is_fan) anc_r <= p;
          else        a_r   <= p;
        end
        2'd1: b_r <= p;
        default: begin
          if (is_strip) a_r <= b_r;
          b_r <= p;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= tng_pkg::MODE_LIST;
      seen_r  <= 2'd0;
      count_r <= '0;
    end else if (cfg_wr_en) begin
      mode_r  <= cfg_wr_data;
      seen_r  <= 2'd0;
      count_r <= '0;
    end else if (take) begin
      if (in_tlast) begin
        seen_r  <= 2'd0;
        count_r <= '0;
      end else begin
        count_r <= count_r + 16'd1;
        if (seen_r != 2'd2)   seen_r <= seen_r + 2'd1;
        else if (!is_strip && !is_fan) seen_r <= 2'd0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/tng_back.sv -----
// Back: cross product, normalizing shift, square root, division and result output.
// Uses tng_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_normal_generator_assert.svh"
module tng_back #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire tng_pkg::job_t q_data,
  output logic               q_pop,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [63:0]        out_tdata,
  output logic               out_tuser,
  output logic               out_tlast
);

  localparam int F    = NORMAL_FRAC_BITS;
  localparam int NW   = F + 32;
  localparam int NEXT = (F + 2 > 16) ? F + 2 : 16;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_CROSS = 8'b00000010,
    ST_SIGN  = 8'b00000100,
    ST_NORM  = 8'b00001000,
    ST_SQ    = 8'b00010000,
    ST_ROOT  = 8'b00100000,
    ST_DSET  = 8'b01000000,
    ST_DIV   = 8'b10000000
  } state_t;

  state_t              state_r;
  logic                emit_r;
  logic                fin_r;
  logic [4:0]          cnt_r;
  tng_pkg::job_t       job_r;
  logic signed [33:0]  prod_a_r, prod_b_r;
  logic signed [34:0]  c_r [3];
  logic [33:0]         mag_r [3];
  logic                neg_r [3];
  logic                deg_r;
  logic [61:0]         sq_r;
  logic [63:0]         q_r, res_r, bit_r;
  logic [31:0]         rem_r [3];
  logic [F:0]          low_r [3];
  logic [F:0]          quo_r [3];
  logic [15:0]         nrm_r [3];

  tng_pkg::edge_t      ma, mb, mc, md;
  logic [33:0]         mmax;
  logic [30:0]         sq_op;
  logic [63:0]         root_sum;
  logic [NW-1:0]       num [3];
  logic [32:0]         trial [3];
  logic                slot_free;
  logic                emit_last;

  assign q_pop     = (state_r == ST_IDLE) & ~emit_r & ~fin_r & q_valid;
  assign slot_free = ~out_tvalid | out_tready;
  assign emit_last = ~job_r.three | (cnt_r == 5'd2);

  // Operand select for the two products of one cross component
  always_comb begin
    case (cnt_r[1:0])
      2'd0: begin ma = job_r.e1y; mb = job_r.e2z; mc = job_r.e1z; md = job_r.e2y; end
      2'd1: begin ma = job_r.e1z; mb = job_r.e2x; mc = job_r.e1x; md = job_r.e2z; end
      default: begin ma = job_r.e1x; mb = job_r.e2y; mc = job_r.e1y; md = job_r.e2x; end
    endcase
  end

  always_comb begin
    mmax = mag_r[0];
    if (mag_r[1] > mmax) mmax = mag_r[1];
    if (mag_r[2] > mmax) mmax = mag_r[2];
  end

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    sq_op = mag_r[0][30:0];
      2'd1:    sq_op = mag_r[1][30:0];
      default: sq_op = mag_r[2][30:0];
    endcase
  end

  assign root_sum = res_r + bit_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i]   = (NW'(mag_r[i][30:0]) << F) + NW'(res_r[31:1]);
      trial[i] = {rem_r[i], low_r[i][F]};
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (q_pop) job_r <= q_data;
      end
      ST_CROSS: begin
        prod_a_r <= ma * mb;
        prod_b_r <= mc * md;
        case (cnt_r[1:0])
          2'd1:    c_r[0] <= 35'(prod_a_r) - 35'(prod_b_r);
          2'd2:    c_r[1] <= 35'(prod_a_r) - 35'(prod_b_r);
          2'd3:    c_r[2] <= 35'(prod_a_r) - 35'(prod_b_r);
          default: ;
        endcase
      end
      ST_SIGN: begin
        for (int i = 0; i < 3; i++) begin
          mag_r[i] <= c_r[i][34] ? 34'(-c_r[i]) : c_r[i][33:0];
          neg_r[i] <= c_r[i][34] ^ job_r.flip;
          nrm_r[i] <= '0;
        end
        deg_r <= (c_r[0] == '0) && (c_r[1] == '0) && (c_r[2] == '0);
      end
      ST_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (mmax[33:31] != 3'd0)      mag_r[i] <= mag_r[i] >> 1;
          else if (mmax[30:22] == 9'd0) mag_r[i] <= mag_r[i] << 8;
          else if (!mmax[30])           mag_r[i] <= mag_r[i] << 1;
        end
        q_r <= '0;
      end
      ST_SQ: begin
        sq_r <= 62'(sq_op) * 62'(sq_op);
        if (cnt_r != 5'd0) q_r <= q_r + 64'(sq_r);
        res_r <= '0;
        bit_r <= 64'h4000_0000_0000_0000;
      end
      ST_ROOT: begin
        if (q_r >= root_sum) begin
          q_r   <= q_r - root_sum;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      ST_DSET: begin
        for (int i = 0; i < 3; i++) begin
          rem_r[i] <= {1'b0, num[i][NW-1:F+1]};
          low_r[i] <= num[i][F:0];
        end
      end
      ST_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (trial[i] >= {1'b0, res_r[31:0]}) begin
            rem_r[i] <= 32'(trial[i] - {1'b0, res_r[31:0]});
            quo_r[i] <= {quo_r[i][F-1:0], 1'b1};
          end else begin
            rem_r[i] <= trial[i][31:0];
            quo_r[i] <= {quo_r[i][F-1:0], 1'b0};
          end
          low_r[i] <= low_r[i] << 1;
        end
      end
      default: ;
    endcase
    // Clamp, restore sign and cut to the field width
    if (fin_r) begin
      for (int i = 0; i < 3; i++) begin
        logic [NEXT-1:0] n;
        n = NEXT'(quo_r[i]);
        if (n > (NEXT'(1) << F)) n = NEXT'(1) << F;
        nrm_r[i] <= neg_r[i] ? 16'(-n) : n[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      emit_r  <= 1'b0;
      fin_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      fin_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (emit_r) begin
            if (slot_free && !fin_r) begin
              cnt_r <= cnt_r + 5'd1;
              if (emit_last) emit_r <= 1'b0;
            end
          end else if (q_pop) begin
            state_r <= ST_CROSS;
            cnt_r   <= '0;
          end
        end
        ST_CROSS: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd3) state_r <= ST_SIGN;
        end
        ST_SIGN: begin
          if ((c_r[0] == '0) && (c_r[1] == '0) && (c_r[2] == '0)) begin
            state_r <= ST_IDLE;
            emit_r  <= 1'b1;
            cnt_r   <= '0;
          end else begin
            state_r <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (mmax[33:30] == 4'b0001) begin
            state_r <= ST_SQ;
            cnt_r   <= '0;
          end
        end
        ST_SQ: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd3) begin
            state_r <= ST_ROOT;
            cnt_r   <= '0;
          end
        end
        ST_ROOT: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) state_r <= ST_DSET;
        end
        ST_DSET: begin
          state_r <= ST_DIV;
          cnt_r   <= '0;
        end
        ST_DIV: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(F)) begin
            state_r <= ST_IDLE;
            fin_r   <= 1'b1;
            emit_r  <= 1'b1;
            cnt_r   <= '0;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Output register: holds one result until its transfer
  logic        out_tvalid_r;
  logic [63:0] out_tdata_r;
  logic        out_tuser_r;
  logic        out_tlast_r;
  tng_pkg::idx_t emit_idx;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    emit_idx = job_r.idx0;
      2'd1:    emit_idx = job_r.idx1;
      default: emit_idx = job_r.idx2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (slot_free) begin
      out_tvalid_r <= (state_r == ST_IDLE) & emit_r & ~fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && (state_r == ST_IDLE) && emit_r && !fin_r) begin
      out_tdata_r <= {emit_idx, nrm_r[2], nrm_r[1], nrm_r[0]};
      out_tuser_r <= deg_r;
      out_tlast_r <= job_r.three & job_r.last & (cnt_r == 5'd2);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  `TNG_ASSERT_IMP(a_deg_zero, out_tvalid && out_tuser, out_tdata[47:0] == 48'd0, "degenerate result with nonzero normal")
  `TNG_ASSERT_IMP(a_pop_idle, q_pop, (state_r == ST_IDLE) && !emit_r, "job taken while busy")
  `TNG_ASSERT_IMP(a_emit_cnt, emit_r && (state_r == ST_IDLE), cnt_r <= 5'd2, "too many results for one triangle")
  `TNG_ASSERT_IMP(a_root_rng, state_r == ST_DSET, res_r[63:32] == '0 && res_r[31:30] != 2'd0, "root out of range")

endmodule
`default_nettype wire

// ----- verif/tb_triangle_normal_generator.sv -----
// Testbench for triangle_normal_generator: random and directed vertex streams in list,
// strip and fan modes, checked against a built-in normal predictor. Depends on tng_pkg.
`timescale 1ns / 1ps
`default_nettype none

class normal_scoreboard;
  logic [1:0]         mode;
  logic signed [31:0] corner_a[3];
  logic signed [31:0] corner_b[3];
  logic signed [31:0] anchor[3];
  logic [15:0]        vcount;
  logic [1:0]         seen;
  logic [15:0]        held_n[3];
  logic               held_degen;
  logic [65:0]        expected_q[$];  // {nx, ny, nz, idx, degen, last}
  int                 mismatches;

  function void set_mode(logic [1:0] m);
    mode   = m;
    vcount = '0;
    seen   = '0;
  endfunction

  function void clear();
    for (int i = 0; i < 3; i++) begin
      corner_a[i] = 0;
      corner_b[i] = 0;
      anchor[i]   = 0;
      held_n[i]   = '0;
    end
    held_degen  = 1'b0;
    mismatches  = 0;
    set_mode(tng_pkg::MODE_LIST);
  endfunction

  function logic [63:0] root64(logic [63:0] q);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > q) b = b >> 2;
    while (b != 0) begin
      if (q >= res + b) begin
        q   = q - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function void face_normal(logic signed [31:0] p0[3], logic signed [31:0] p1[3],
                            logic signed [31:0] p2[3], logic flip);
    logic signed [63:0] e1[3];
    logic signed [63:0] e2[3];
    logic signed [63:0] c[3];
    logic [63:0]        mag[3];
    logic [63:0]        m, q, r, n;
    logic               neg[3];
    for (int i = 0; i < 3; i++) begin
      e1[i] = p1[i] - p0[i];
      e2[i] = p2[i] - p0[i];
    end
    c[0] = e1[1] * e2[2] - e1[2] * e2[1];
    c[1] = e1[2] * e2[0] - e1[0] * e2[2];
    c[2] = e1[0] * e2[1] - e1[1] * e2[0];
    m = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = (c[i] < 0) != flip;
      mag[i] = (c[i] < 0) ? -c[i] : c[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      for (int i = 0; i < 3; i++) held_n[i] = '0;
      held_degen = 1'b1;
      return;
    end
    while (m >= (64'd1 << 31)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (m < (64'd1 << 30)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    q = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    r = root64(q);
    for (int i = 0; i < 3; i++) begin
      n = ((mag[i] << 14) + (r >> 1)) / r;
      if (n > (64'd1 << 14)) n = 64'd1 << 14;
      held_n[i] = neg[i] ? 16'(-n) : 16'(n);
    end
    held_degen = 1'b0;
  endfunction

  function void push(logic [15:0] idx, logic last);
    expected_q.insert(expected_q.size(),
                      {held_n[0], held_n[1], held_n[2], idx, held_degen, last});
  endfunction

  // Note one accepted vertex and queue the normals it releases.
  function void note_vertex(logic [47:0] data, logic last);
    logic signed [31:0] p[3];
    logic [15:0]        k;
    k = vcount;
    p[0] = $signed(data[15:0]);
    p[1] = $signed(data[31:16]);
    p[2] = $signed(data[47:32]);
    if (seen == 0) begin
      if (mode == tng_pkg::MODE_FAN) anchor = p;
      else corner_a = p;
      seen = 1;
    end else if (seen == 1) begin
      corner_b = p;
      seen = 2;
    end else if (mode == tng_pkg::MODE_STRIP) begin
      face_normal(corner_a, corner_b, p, k[0]);
      push(k - 16'd2, 1'b0);
      if (last) begin
        push(k - 16'd1, 1'b0);
        push(k, 1'b1);
      end
      corner_a = corner_b;
      corner_b = p;
    end else if (mode == tng_pkg::MODE_FAN) begin
      face_normal(anchor, corner_b, p, 1'b0);
      push(k - 16'd1, 1'b0);
      if (last) begin
        push(k, 1'b0);
        push(16'd0, 1'b1);
      end
      corner_b = p;
    end else begin
      face_normal(corner_a, corner_b, p, 1'b0);
      push(k - 16'd2, 1'b0);
      push(k - 16'd1, 1'b0);
      push(k, last);
      seen = 0;
    end
    vcount = k + 16'd1;
    if (last) begin
      vcount = '0;
      seen   = '0;
    end
  endfunction

  function void check_normal(logic [63:0] data, logic degen, logic last);
    logic [65:0] want;
    logic [65:0] got;
    got = {data[15:0], data[31:16], data[47:32], data[63:48], degen, last};
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected normal %h", got);
      return;
    end
    want = expected_q.pop_front();
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("normal mismatch: expected nx=%h ny=%h nz=%h idx=%0d degen=%b last=%b",
                 want[65:50], want[49:34], want[33:18], want[17:2], want[1], want[0]);
        $display("                 actual   nx=%h ny=%h nz=%h idx=%0d degen=%b last=%b",
                 got[65:50], got[49:34], got[33:18], got[17:2], got[1], got[0]);
      end
    end
  endfunction
endclass

module tb_triangle_normal_generator;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  normal_scoreboard normals;
  int               hold_off_cycles;
  bit               drain_mode;

  triangle_normal_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 90);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Most coordinates are random over the whole field; a share hit the field extremes or small values.
  function automatic logic [15:0] coord();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 7));
      default: return 16'($urandom);
    endcase
  endfunction

  // Valid stays high after a transfer until the next call drops or reloads it.
  task automatic send_vertex(logic [47:0] data, logic last, bit no_gap);
    int gap;
    gap = no_gap ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    normals.note_vertex(data, last);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (normals.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    normals.set_mode(m);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_range(int len, bit degen_pick);
    logic [47:0] v;
    for (int i = 0; i < len; i++) begin
      v = {coord(), coord(), coord()};
      if (degen_pick && i == 2) v = 48'h0;
      send_vertex(v, i == len - 1, 1'b0);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      out_tready <= ($urandom_range(0, 3) != 0) || drain_mode;
      @(posedge clk);
      if (out_tvalid && out_tready)
        normals.check_normal(out_tdata, out_tuser, out_tlast);
      if (!drain_mode && $urandom_range(0, 30) == 0) begin
        stall = gap_len();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int sent;
    int len;
    normals = new();
    normals.clear();
    hold_off_cycles = 0;
    drain_mode  = 1'b0;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = tng_pkg::MODE_LIST;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, degenerate triangles, each mode and short ranges.
    send_vertex({16'h0000, 16'h0000, 16'h8000}, 1'b0, 1'b0);
    send_vertex({16'h0000, 16'h7FFF, 16'h0000}, 1'b0, 1'b0);
    send_vertex({16'h7FFF, 16'h0000, 16'h0000}, 1'b0, 1'b0);
    send_vertex({16'h0001, 16'h0001, 16'h0001}, 1'b0, 1'b0);
    send_vertex({16'h0001, 16'h0001, 16'h0001}, 1'b0, 1'b0);
    send_vertex({16'h0001, 16'h0001, 16'h0001}, 1'b0, 1'b0);
    send_vertex({16'h8000, 16'h8000, 16'hFFFF}, 1'b0, 1'b0);
    send_vertex({16'h7FFF, 16'h8000, 16'h7FFF}, 1'b1, 1'b0);
    write_mode(tng_pkg::MODE_STRIP);
    send_range(5, 1'b1);
    send_range(2, 1'b0);
    write_mode(tng_pkg::MODE_FAN);
    send_range(5, 1'b0);
    send_range(1, 1'b0);
    write_mode(2'd3);
    send_range(3, 1'b0);
    // Restart a range midway by a mode write.
    write_mode(tng_pkg::MODE_STRIP);
    send_vertex(48'h0001_0002_0003, 1'b0, 1'b0);
    write_mode(tng_pkg::MODE_LIST);

    // Fill the block while the receiver holds off.
    hold_off_cycles = 1500;
    for (int i = 0; i < 12; i++)
      send_vertex({coord(), coord(), coord()}, i == 11, 1'b1);

    sent = 0;
    while (sent < 230) begin
      write_mode(2'($urandom_range(0, 3)));
      for (int r = 0; r < 6; r++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
        send_range(len, $urandom_range(0, 9) == 0);
        sent += len;
      end
      // Trailing vertices without a range end, cleared by the next mode write.
      if ($urandom_range(0, 3) == 0) begin
        send_vertex({coord(), coord(), coord()}, 1'b0, 1'b0);
        sent++;
      end
    end

    drain_mode = 1'b1;
    wait_idle();
    if (normals.mismatches == 0 && normals.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
